// ----- hw/rtl/modem_response_line_capture_macros.svh -----
// Assertion macros shared by the checker of the modem response line capture.
// Depends on nothing; the asserting file provides clk_i and rst_ni.
`ifndef MODEM_RESPONSE_LINE_CAPTURE_MACROS_SVH
`define MODEM_RESPONSE_LINE_CAPTURE_MACROS_SVH

// Clocked assertion, switched off while reset is active.
`define MRLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication that must hold in the same cycle.
`define MRLC_ASSERT_IMP(label, ante, cons, msg) \
  `MRLC_ASSERT(label, (ante) |-> (cons), msg)

// Implication that must hold in the following cycle.
`define MRLC_ASSERT_NEXT(label, ante, cons, msg) \
  `MRLC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/mrlc_pkg.sv -----
// Package of the modem response line capture: sizes, character codes and
// the types shared by the control logic, the top level and the checker.
package mrlc_pkg;

  // Line buffer size in bytes (8 to 255).
  localparam int unsigned LINE_CAPACITY = 128;
  localparam int unsigned ADDR_W = $clog2(LINE_CAPACITY);
  localparam logic [7:0] CAP_COUNT = 8'(LINE_CAPACITY);

  // Characters that end a response line.
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_O  = 8'h4F;
  localparam logic [7:0] CHAR_K  = 8'h4B;
  localparam logic [7:0] CHAR_E  = 8'h45;
  localparam logic [7:0] CHAR_R  = 8'h52;

  typedef enum logic [1:0] {
    OP_RECEIVE = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_OK       = 2'd1,
    CAUSE_ERROR    = 2'd2,
    CAUSE_OVERFLOW = 2'd3
  } cause_e;

  // Status part of one result word.
  typedef struct packed {
    logic       line_ready;
    logic [7:0] line_length;
    logic       byte_dropped;
    cause_e     completion_cause;
  } status_t;

  // Access to the line buffer for one accepted word.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              read_ok;
  } ram_req_t;

endpackage

// ----- hw/rtl/mrlc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mrlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and read register carry no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mrlc_ctrl.sv -----
// Line capture control: fill count, held line, tail match and completion.
// Depends on mrlc_pkg; drives the line buffer RAM request.
module mrlc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [6:0]        read_index_i,
  output mrlc_pkg::status_t status_o,
  output mrlc_pkg::ram_req_t ram_req_o
);
  import mrlc_pkg::*;

  logic [7:0]  fill_q, fill_d;
  logic [7:0]  held_len_q, held_len_d;
  logic        held_q, held_d;
  logic [47:0] tail_q, tail_d;

  logic [47:0] tail_shift;
  logic [7:0]  fill_inc;
  logic [7:0]  idx_ext;
  logic        ok_match;
  logic        error_match;
  op_e         op;

  assign op         = op_e'(operation_i);
  assign tail_shift = {tail_q[39:0], rx_byte_i};
  assign fill_inc   = fill_q + 8'd1;
  assign idx_ext    = {1'b0, read_index_i};

  // Endings are checked on the tail as it stands after this byte.
  assign ok_match = (rx_byte_i == CHAR_CR) && (fill_inc >= 8'd3) &&
                    (tail_shift[23:16] == CHAR_O) && (tail_shift[15:8] == CHAR_K);
  assign error_match = (rx_byte_i == CHAR_CR) && (fill_inc >= 8'd6) &&
                       (tail_shift[47:40] == CHAR_E) && (tail_shift[39:32] == CHAR_R) &&
                       (tail_shift[31:24] == CHAR_R) && (tail_shift[23:16] == CHAR_O) &&
                       (tail_shift[15:8] == CHAR_R);

  // Next state and status for the word on the input.
  always_comb begin
    fill_d     = fill_q;
    held_len_d = held_len_q;
    held_d     = held_q;
    tail_d     = tail_q;

    status_o.byte_dropped     = 1'b0;
    status_o.completion_cause = CAUSE_NONE;

    ram_req_o.we      = 1'b0;
    ram_req_o.waddr   = fill_q[ADDR_W-1:0];
    ram_req_o.wdata   = rx_byte_i;
    ram_req_o.re      = accept_i;
    ram_req_o.raddr   = idx_ext[ADDR_W-1:0];
    ram_req_o.read_ok = 1'b0;

    unique case (op)
      OP_RECEIVE: begin
        if (held_q) begin
          status_o.byte_dropped = 1'b1;
        end else if (fill_q >= CAP_COUNT) begin
          // Buffer full: the byte is lost and the line closes at capacity.
          status_o.byte_dropped     = 1'b1;
          status_o.completion_cause = CAUSE_OVERFLOW;
          held_len_d = fill_q;
          fill_d     = 8'd0;
          held_d     = 1'b1;
          tail_d     = 48'd0;
        end else begin
          ram_req_o.we = accept_i;
          fill_d       = fill_inc;
          tail_d       = tail_shift;
          if (ok_match || error_match) begin
            status_o.completion_cause = ok_match ? CAUSE_OK : CAUSE_ERROR;
            held_len_d = fill_inc;
            fill_d     = 8'd0;
            held_d     = 1'b1;
            tail_d     = 48'd0;
          end
        end
      end
      OP_READ: begin
        ram_req_o.read_ok = held_q && (idx_ext < held_len_q) && (idx_ext < CAP_COUNT);
      end
      OP_RELEASE: begin
        held_d = 1'b0;
      end
      default: begin
        // Unused operation code: status only.
      end
    endcase

    status_o.line_ready  = held_d;
    status_o.line_length = held_d ? held_len_d : 8'd0;
  end

  // State advances only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= 8'd0;
      held_len_q <= 8'd0;
      held_q     <= 1'b0;
      tail_q     <= 48'd0;
    end else if (accept_i) begin
      fill_q     <= fill_d;
      held_len_q <= held_len_d;
      held_q     <= held_d;
      tail_q     <= tail_d;
    end
  end

endmodule

// ----- hw/rtl/modem_response_line_capture.sv -----
// Top level of the modem response line capture: stream ports, result register
// and line buffer. Depends on mrlc_pkg, mrlc_ctrl and mrlc_ram.
//
// One word is accepted in every cycle and its result word appears in the output
// register in the next cycle; a new word is taken while a result waits as
// long as the output is being read in the same cycle. Each result comes from the
// single pass through the tail compare and the line buffer RAM, whose one
// write port stores received bytes and whose registered read port serves
// buffer reads. The buffer needs no clearing after reset, because only
// positions written during the held line are ever returned.
module modem_response_line_capture (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [14:8] read_index, [15] zero
  input  logic [15:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] line_ready, [8:1] line_length, [16:9] read_data, [17] byte_dropped,
  // [19:18] completion_cause, [23:20] zero
  output logic [23:0] m_axis_tdata
);
  import mrlc_pkg::*;

  logic     accept;
  status_t  status;
  ram_req_t ram_req;
  logic [7:0] ram_rdata;

  logic    out_valid_q, out_valid_d;
  status_t status_q;
  logic    read_ok_q;
  logic [7:0] read_data;

  // The output register frees up when it is empty or read this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mrlc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (s_axis_tuser),
    .rx_byte_i    (s_axis_tdata[7:0]),
    .read_index_i (s_axis_tdata[14:8]),
    .status_o     (status),
    .ram_req_o    (ram_req)
  );

  // The read port is enabled only on accept, so its data holds while stalled.
  mrlc_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      read_ok_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        read_ok_q <= ram_req.read_ok;
      end
    end
  end

  // Status payload of the result word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status;
    end
  end

  assign read_data     = read_ok_q ? ram_rdata : 8'd0;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, status_q.completion_cause, status_q.byte_dropped,
                          read_data, status_q.line_length, status_q.line_ready};

endmodule

// ----- hw/rtl/mrlc_checker.sv -----
// Port-level checker of the modem response line capture and its bind.
// Depends on mrlc_pkg and modem_response_line_capture_macros.svh.
`include "modem_response_line_capture_macros.svh"

module mrlc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import mrlc_pkg::*;

  // A stalled result word keeps its contents.
  `MRLC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // With no line held, length and read data are both zero.
  `MRLC_ASSERT_IMP(a_idle_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[16:1] == 16'd0, "length or data without a held line")

  // A completion always leaves a held line.
  `MRLC_ASSERT_IMP(a_cause_held, m_axis_tvalid && (m_axis_tdata[19:18] != CAUSE_NONE), m_axis_tdata[0], "completion without a held line")

  // An overflow completes with a full buffer and drops the byte.
  `MRLC_ASSERT_IMP(a_overflow_len, m_axis_tvalid && (m_axis_tdata[19:18] == CAUSE_OVERFLOW), (m_axis_tdata[8:1] == CAP_COUNT) && m_axis_tdata[17], "overflow with wrong length")

endmodule

bind modem_response_line_capture mrlc_checker u_mrlc_checker (.*);
